@@ rtl/core/ccc_pkg.sv @@
// Shared constants, types and state codes for the color calibrate and classify block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package ccc_pkg;

    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int CHANNELS          = 4;
    localparam int RAW_W             = 16;
    localparam int MAP_W             = 8;
    localparam int ENTRY_IDX_W       = 4;
    localparam int DIST_W            = 18;
    localparam int NUM_W             = 24;   // |raw - dark| * 255 fits in 24 bits
    localparam int DIV_STEPS         = 8;    // one quotient bit per step
    localparam int CFG_ADDR_W        = 3;
    localparam int DIST_MAX          = 260100;

    localparam logic [MAP_W-1:0] FULL_SCALE = 8'd255;

    // s_tuser codes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_SEARCH,
        ST_OUT
    } ccc_state_t;

    // status of one calibration lane
    typedef struct packed {
        logic             done;
        logic             err;
        logic [MAP_W-1:0] value;
    } ccc_lane_t;

    // status of the nearest-entry search
    typedef struct packed {
        logic                   done;
        logic [ENTRY_IDX_W-1:0] index;
        logic [DIST_W-1:0]      distance;
    } ccc_near_t;

endpackage

@@ rtl/core/color_calibrate_and_classify.sv @@
// Top level of the color calibrate and classify block: config registers, control FSM,
// four calibration lanes, nearest-entry search and output register.
// Depends on ccc_pkg, ccc_map_lane and ccc_nearest.
//
//  channel | direction | tdata fields (low bit up)                       | tuser
//  --------+-----------+-------------------------------------------------+------------
//  s_      | in        | entry_index, raw_red/green/blue/clear,          | operation
//          |           | ref_red/green/blue/clear, 4 pad bits            |
//  m_      | out       | color_index, mapped_red/green/blue/clear,       | cal_error
//          |           | min_distance, 2 pad bits                        |
//  cfg_    | in        | write enable, index 0..7, 16-bit data           | -
//
// Classify, from one input transfer to the next: 1 setup + 8 divider steps in every lane,
// then one table entry per cycle plus one compare stage, then the hand-off to the output
// register. Load: the table write happens at the input transfer.
// Reset is synchronous and clears the table, the config registers and all control.
// A result waiting on m_tready does not hold the next input transfer; only a finished
// result that finds the output register still full waits in ST_OUT.
module color_calibrate_and_classify #(
    parameter int TABLE_ENTRIES = ccc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[3:0], raw_red[19:4], raw_green[35:20], raw_blue[51:36],
    // raw_clear[67:52], ref_red[75:68], ref_green[83:76], ref_blue[91:84],
    // ref_clear[99:92], zero pad[103:100]
    input  logic [103:0]                      s_tdata,
    // operation[0]
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // color_index[3:0], mapped_red[11:4], mapped_green[19:12], mapped_blue[27:20],
    // mapped_clear[35:28], min_distance[53:36], zero pad[55:54]
    output logic [55:0]                       m_tdata,
    // cal_error[0]
    output logic                              m_tuser,

    input  logic                              cfg_we,
    input  logic [ccc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ccc_pkg::RAW_W-1:0]         cfg_wdata
);

    localparam int NCH = ccc_pkg::CHANNELS;
    localparam int RW  = ccc_pkg::RAW_W;
    localparam int MW  = ccc_pkg::MAP_W;

    ccc_pkg::ccc_state_t state_reg, state_next;

    logic [NCH-1:0][RW-1:0] dark_reg, white_reg;
    ccc_pkg::ccc_lane_t     lane [NCH];
    ccc_pkg::ccc_near_t     near;
    logic [NCH-1:0][MW-1:0] mapped;
    logic [NCH-1:0]         lane_done, lane_err;

    logic s_xfer, out_free, map_done;
    logic lane_start, tbl_we, search_start, out_load;

    // result waiting for the output register
    logic [ccc_pkg::ENTRY_IDX_W-1:0] res_idx_reg;
    logic [NCH-1:0][MW-1:0]          res_map_reg;
    logic [ccc_pkg::DIST_W-1:0]      res_dist_reg;
    logic                            res_err_reg;

    logic        m_tvalid_reg;
    logic [55:0] m_tdata_reg;
    logic        m_tuser_reg;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign map_done = &lane_done;

    // config: index 0..3 dark, 4..7 white
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_reg  <= '0;
            white_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr[2]) begin
                white_reg[cfg_addr[1:0]] <= cfg_wdata;
            end else begin
                dark_reg[cfg_addr[1:0]]  <= cfg_wdata;
            end
        end
    end

    // calibration lanes, one per color channel
    for (genvar c = 0; c < NCH; c++) begin : g_lane
        ccc_map_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .raw     (s_tdata[4 + c*RW +: RW]),
            .dark    (dark_reg[c]),
            .white   (white_reg[c]),
            .lane_o  (lane[c])
        );
        assign lane_done[c] = lane[c].done;
        assign lane_err[c]  = lane[c].err;
        assign mapped[c]    = lane[c].value;
    end

    ccc_nearest #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_nearest (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tbl_we),
        .wr_index (s_tdata[3:0]),
        .wr_entry (s_tdata[99:68]),
        .start    (search_start),
        .mapped   (mapped),
        .near_o   (near)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccc_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (s_tuser == ccc_pkg::OP_CLASSIFY) ? ccc_pkg::ST_MAP
                                                                   : ccc_pkg::ST_OUT;
                end
            end
            ccc_pkg::ST_MAP: begin
                if (map_done) state_next = ccc_pkg::ST_SEARCH;
            end
            ccc_pkg::ST_SEARCH: begin
                if (near.done) state_next = ccc_pkg::ST_OUT;
            end
            ccc_pkg::ST_OUT: begin
                if (out_free) state_next = ccc_pkg::ST_IDLE;
            end
            default: state_next = ccc_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_tready     = 1'b0;
        lane_start   = 1'b0;
        tbl_we       = 1'b0;
        search_start = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ccc_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                lane_start = s_tvalid && (s_tuser == ccc_pkg::OP_CLASSIFY);
                tbl_we     = s_tvalid && (s_tuser == ccc_pkg::OP_LOAD);
            end
            ccc_pkg::ST_MAP:    search_start = map_done;
            ccc_pkg::ST_SEARCH: ;
            ccc_pkg::ST_OUT:    out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // result capture: a load answers all zero
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            res_idx_reg  <= '0;
            res_map_reg  <= '0;
            res_dist_reg <= '0;
            res_err_reg  <= 1'b0;
        end else if (state_reg == ccc_pkg::ST_SEARCH && near.done) begin
            res_idx_reg  <= near.index;
            res_map_reg  <= mapped;
            res_dist_reg <= near.distance;
            res_err_reg  <= |lane_err;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {2'b00, res_dist_reg, res_map_reg[3], res_map_reg[2],
                            res_map_reg[1], res_map_reg[0], res_idx_reg};
            m_tuser_reg <= res_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ rtl/core/ccc_map_lane.sv @@
// One calibration lane: (raw - dark) * 255 / (white - dark), truncated, clamped to 0..255.
// Restoring division, one quotient bit per cycle. Depends on ccc_pkg.
module ccc_map_lane (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ccc_pkg::RAW_W-1:0]   raw,
    input  logic [ccc_pkg::RAW_W-1:0]   dark,
    input  logic [ccc_pkg::RAW_W-1:0]   white,
    output ccc_pkg::ccc_lane_t          lane_o
);

    localparam int RW = ccc_pkg::RAW_W;
    localparam int NW = ccc_pkg::NUM_W;
    localparam int MW = ccc_pkg::MAP_W;

    logic [RW:0]   num_diff, den_diff;
    logic [RW-1:0] adiff_reg, aden_reg;
    logic          neg_reg, zero_reg, sat_reg;
    logic          setup_reg, busy_reg, done_reg, err_reg;
    logic [2:0]    cnt_reg;
    logic [NW-1:0] rem_reg, num_full, dsh_ext;
    logic [NW-2:0] dsh_reg;
    logic [MW-1:0] q_reg, q_next, value_reg;
    logic          ge;

    assign num_diff = {1'b0, raw}   - {1'b0, dark};
    assign den_diff = {1'b0, white} - {1'b0, dark};

    // 255 * x as (x << 8) - x
    assign num_full = {adiff_reg, 8'b0} - NW'(adiff_reg);
    assign dsh_ext  = {1'b0, dsh_reg};
    assign ge       = rem_reg >= dsh_ext;
    assign q_next   = {q_reg[MW-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
            value_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                setup_reg <= 1'b1;
                adiff_reg <= num_diff[RW] ? RW'(-num_diff) : num_diff[RW-1:0];
                aden_reg  <= den_diff[RW] ? RW'(-den_diff) : den_diff[RW-1:0];
                neg_reg   <= num_diff[RW] ^ den_diff[RW];
                zero_reg  <= (den_diff == '0);
            end else if (setup_reg) begin
                setup_reg <= 1'b0;
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                rem_reg   <= num_full;
                sat_reg   <= num_full >= {aden_reg, 8'b0};
                dsh_reg   <= {aden_reg, 7'b0};
                q_reg     <= '0;
            end else if (busy_reg) begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_ext;
                end
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'(ccc_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    err_reg  <= zero_reg;
                    if (zero_reg || neg_reg) begin
                        value_reg <= '0;
                    end else if (sat_reg) begin
                        value_reg <= ccc_pkg::FULL_SCALE;
                    end else begin
                        value_reg <= q_next;
                    end
                end
            end
        end
    end

    assign lane_o.done  = done_reg;
    assign lane_o.err   = err_reg;
    assign lane_o.value = value_reg;

endmodule

@@ rtl/core/ccc_nearest.sv @@
// Reference color table and nearest-entry search: four squared-difference lanes,
// one table entry per cycle, then a registered compare. Depends on ccc_pkg.
module ccc_nearest #(
    parameter int TABLE_ENTRIES = ccc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           wr_en,
    input  logic [ccc_pkg::ENTRY_IDX_W-1:0]                wr_index,
    input  logic [ccc_pkg::CHANNELS*ccc_pkg::MAP_W-1:0]    wr_entry,
    input  logic                                           start,
    input  logic [ccc_pkg::CHANNELS-1:0][ccc_pkg::MAP_W-1:0] mapped,
    output ccc_pkg::ccc_near_t                             near_o
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CMP_W = ccc_pkg::ENTRY_IDX_W + 1;
    localparam int EW    = ccc_pkg::CHANNELS * ccc_pkg::MAP_W;
    localparam int DW    = ccc_pkg::DIST_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [EW-1:0]    table_reg [TABLE_ENTRIES];
    logic [EW-1:0]    entry;
    logic             wr_ok;
    logic             walk_reg, sum_vld_reg, sum_last_reg, done_reg;
    logic [IDX_W-1:0] walk_cnt_reg, sum_idx_reg, best_idx_reg;
    logic [DW-1:0]    sum, sum_reg, best_reg;
    logic [ccc_pkg::CHANNELS-1:0][15:0] sq;

    assign wr_ok = wr_en && ({1'b0, wr_index} < CMP_W'(TABLE_ENTRIES));
    assign entry = table_reg[walk_cnt_reg];

    // squared difference lanes
    for (genvar c = 0; c < ccc_pkg::CHANNELS; c++) begin : g_sq
        logic signed [8:0]  d;
        logic signed [17:0] p;
        assign d     = $signed({1'b0, entry[c*ccc_pkg::MAP_W +: ccc_pkg::MAP_W]})
                     - $signed({1'b0, mapped[c]});
        assign p     = d * d;
        assign sq[c] = p[15:0];
    end

    assign sum = DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]) + DW'(sq[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                table_reg[i] <= '0;
            end
        end else if (wr_ok) begin
            table_reg[wr_index[IDX_W-1:0]] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg     <= 1'b0;
            walk_cnt_reg <= '0;
            sum_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg    <= 1'b0;
            sum_vld_reg <= walk_reg;
            if (start) begin
                walk_reg     <= 1'b1;
                walk_cnt_reg <= '0;
            end else if (walk_reg) begin
                sum_reg      <= sum;
                sum_idx_reg  <= walk_cnt_reg;
                sum_last_reg <= (walk_cnt_reg == LAST_IDX);
                if (walk_cnt_reg == LAST_IDX) begin
                    walk_reg <= 1'b0;
                end else begin
                    walk_cnt_reg <= walk_cnt_reg + 1'b1;
                end
            end
            if (sum_vld_reg) begin
                // strict compare keeps the lowest index on a tie
                if (sum_idx_reg == '0 || sum_reg < best_reg) begin
                    best_reg     <= sum_reg;
                    best_idx_reg <= sum_idx_reg;
                end
                done_reg <= sum_last_reg;
            end
        end
    end

    assign near_o.done     = done_reg;
    assign near_o.index    = ccc_pkg::ENTRY_IDX_W'(best_idx_reg);
    assign near_o.distance = best_reg;

endmodule

@@ rtl/core/ccc_checker.sv @@
// Port-level checks for color_calibrate_and_classify, attached by bind.
// Depends on ccc_pkg.
module ccc_checker #(
    parameter int TABLE_ENTRIES = ccc_pkg::TABLE_ENTRIES_DEF
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tuser
);

    localparam int CMP_W = ccc_pkg::ENTRY_IDX_W + 1;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // one item at a time: no input transfer right after another
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high in the cycle after an input transfer");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[53:36] <= 18'(ccc_pkg::DIST_MAX))
        else $error("min_distance out of range");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> {1'b0, m_tdata[3:0]} < CMP_W'(TABLE_ENTRIES))
        else $error("color_index beyond the table");

endmodule

bind color_calibrate_and_classify ccc_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_ccc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
